/* rtl/strongly_connected_components_top_macros.svh */
// Assertion macros shared by the strongly connected components RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef STRONGLY_CONNECTED_COMPONENTS_TOP_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/scc_pkg.sv */
// Package of the strongly connected components engine: sizes, codes and types.
// Used by every module of the block; depends on nothing.
package scc_pkg;

	localparam int MaxVertices = 1024;
	localparam int MaxEdges    = 4096;
	localparam int VW  = 10;  // vertex number
	localparam int CW  = 11;  // vertex count, 0..MaxVertices
	localparam int EW  = 13;  // edge count and adjacency position, 0..MaxEdges
	localparam int EAW = 12;  // edge store address

	localparam logic [1:0] REQ_ADD    = 2'd0;
	localparam logic [1:0] REQ_DECOMP = 2'd1;
	localparam logic [1:0] REQ_QUERY  = 2'd2;
	localparam logic [1:0] REQ_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]    req_type;
		logic [VW-1:0] vertex;
		logic [VW-1:0] edge_target;
	} req_t;

	typedef struct packed {
		logic [1:0]    status;
		logic [VW-1:0] component;
		logic [CW-1:0] component_count;
	} res_t;

	typedef struct packed {
		logic [VW-1:0] src;
		logic [VW-1:0] dst;
	} edge_pair_t;

	typedef struct packed {
		logic           en;
		logic [EAW-1:0] addr;
		edge_pair_t     data;
	} edge_wr_t;

	typedef struct packed {
		logic          busy;
		logic          done;
		logic          labels_valid;
		logic [CW-1:0] count;
	} eng_stat_t;

	typedef struct packed {
		logic [VW-1:0] v;
		logic [EW-1:0] pos;
		logic [EW-1:0] lim;
	} stk_ent_t;

endpackage

/* rtl/scc_edge_store.sv */
// Edge store: one memory of source and target pairs, one write and one registered read port.
// Depends on scc_pkg.
module scc_edge_store import scc_pkg::*; (
	input  logic           clk,
	input  edge_wr_t       wr,
	input  logic [EAW-1:0] rd_addr,
	output edge_pair_t     rd_data
);

	edge_pair_t mem [MaxEdges];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/scc_engine.sv */
// Decomposition engine: adjacency build, both depth-first passes, component labels.
// Depends on scc_pkg and the assertion macros; reads the edge store.
`include "strongly_connected_components_top_macros.svh"
module scc_engine import scc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  logic [CW-1:0]  n,
	input  logic [EW-1:0]  edge_total,
	output logic [EAW-1:0] edge_rd_addr,
	input  edge_pair_t     edge_rd,
	input  logic [VW-1:0]  q_addr,
	output logic [VW-1:0]  q_data,
	output eng_stat_t      stat
);

	localparam logic [4:0] S_IDLE     = 5'd0;
	localparam logic [4:0] S_CLR      = 5'd1;
	localparam logic [4:0] S_CNT_RD   = 5'd2;
	localparam logic [4:0] S_CNT_OFF  = 5'd3;
	localparam logic [4:0] S_CNT_WR   = 5'd4;
	localparam logic [4:0] S_PFX_RD   = 5'd5;
	localparam logic [4:0] S_PFX_WR   = 5'd6;
	localparam logic [4:0] S_FIL_RD   = 5'd7;
	localparam logic [4:0] S_FIL_OFF  = 5'd8;
	localparam logic [4:0] S_FIL_WR   = 5'd9;
	localparam logic [4:0] S_OUT_RD   = 5'd10;
	localparam logic [4:0] S_BOUT_RD  = 5'd11;
	localparam logic [4:0] S_BOUT_FIN = 5'd12;
	localparam logic [4:0] S_OUT_CHK  = 5'd13;
	localparam logic [4:0] S_LOAD     = 5'd14;
	localparam logic [4:0] S_W_STEP   = 5'd15;
	localparam logic [4:0] S_W_NB     = 5'd16;
	localparam logic [4:0] S_W_VIS    = 5'd17;
	localparam logic [4:0] S_W_POP    = 5'd18;
	localparam logic [4:0] S_CLR2     = 5'd19;
	localparam logic [4:0] S_FIN      = 5'd20;

	localparam logic [CW-1:0] LastV = CW'(MaxVertices - 1);

	// Memories. Offsets hold the running end of each adjacency list once built.
	logic [EW-1:0]  out_off [MaxVertices];
	logic [EW-1:0]  in_off  [MaxVertices];
	logic [VW-1:0]  out_nb  [MaxEdges];
	logic [VW-1:0]  in_nb   [MaxEdges];
	logic           vis_mem [MaxVertices];
	logic [VW-1:0]  fin_mem [MaxVertices];
	stk_ent_t       stk_mem [MaxVertices];
	logic [VW-1:0]  comp_mem [MaxVertices];

	logic [4:0]    state_q, state_d;
	logic [CW-1:0] comp_total_q;
	logic          labels_valid_q;
	logic          pass_q;
	logic [CW-1:0] idx_q, bi_q, done_q, label_q, depth_q;
	logic [EW-1:0] ei_q, osum_q, isum_q;
	logic [VW-1:0] tgt_q, e_src_q, e_dst_q, cur_v_q;
	logic [EW-1:0] cur_pos_q, cur_end_q;

	logic [EW-1:0] oo_a_q, oo_b_q, io_a_q, io_b_q;
	logic [VW-1:0] onb_q, inb_q, fin_rd_q;
	logic          vis_rd_q;
	stk_ent_t      stk_rd_q;

	logic          oo_we, io_we, onb_we, inb_we, vis_we, vis_wd, fin_we, stk_we, comp_we;
	logic [VW-1:0] oo_wa, io_wa, vis_wa, comp_wa, comp_wd, oo_ra, oo_rb, io_ra, io_rb;
	logic [VW-1:0] vis_ra;
	logic [EW-1:0] oo_wd, io_wd;
	logic [EAW-1:0] onb_wa, inb_wa;
	logic [VW-1:0] onb_wd, inb_wd;
	logic          e_keep, has_edge;
	logic [VW-1:0] nb_u;
	logic [CW-1:0] bi_m1, depth_m1, depth_m2;

	assign e_keep   = ({1'b0, edge_rd.src} < n) && ({1'b0, edge_rd.dst} < n);
	assign has_edge = cur_pos_q < cur_end_q;
	assign nb_u     = pass_q ? inb_q : onb_q;
	assign bi_m1    = bi_q - CW'(1);
	assign depth_m1 = depth_q - CW'(1);
	assign depth_m2 = depth_q - CW'(2);
	assign edge_rd_addr = ei_q[EAW-1:0];

	// Memory control per state.
	always_comb begin
		oo_we = 1'b0; io_we = 1'b0; onb_we = 1'b0; inb_we = 1'b0;
		vis_we = 1'b0; vis_wd = 1'b0; fin_we = 1'b0; stk_we = 1'b0; comp_we = 1'b0;
		oo_wa = e_src_q; io_wa = e_dst_q; oo_wd = oo_a_q + EW'(1); io_wd = io_a_q + EW'(1);
		onb_wa = oo_a_q[EAW-1:0]; inb_wa = io_a_q[EAW-1:0];
		onb_wd = e_dst_q; inb_wd = e_src_q;
		vis_wa = tgt_q; comp_wa = tgt_q; comp_wd = label_q[VW-1:0];
		oo_ra = tgt_q - VW'(1); oo_rb = tgt_q; io_ra = tgt_q - VW'(1); io_rb = tgt_q;
		vis_ra = idx_q[VW-1:0];
		unique case (state_q)
			S_CLR: begin
				oo_we = 1'b1; io_we = 1'b1; vis_we = 1'b1;
				oo_wa = idx_q[VW-1:0]; io_wa = idx_q[VW-1:0]; vis_wa = idx_q[VW-1:0];
				oo_wd = '0; io_wd = '0;
			end
			S_CNT_OFF, S_FIL_OFF: begin
				oo_ra = edge_rd.src;
				io_ra = edge_rd.dst;
			end
			S_CNT_WR: begin
				oo_we = 1'b1; io_we = 1'b1;
			end
			S_PFX_RD: begin
				oo_ra = idx_q[VW-1:0];
				io_ra = idx_q[VW-1:0];
			end
			S_PFX_WR: begin
				oo_we = 1'b1; io_we = 1'b1;
				oo_wa = idx_q[VW-1:0]; io_wa = idx_q[VW-1:0];
				oo_wd = osum_q; io_wd = isum_q;
			end
			S_FIL_WR: begin
				oo_we = 1'b1; io_we = 1'b1; onb_we = 1'b1; inb_we = 1'b1;
			end
			S_BOUT_FIN: begin
				vis_ra = fin_rd_q;
			end
			S_OUT_CHK: begin
				if (!vis_rd_q) begin
					vis_we = 1'b1; vis_wd = 1'b1;
					comp_we = pass_q;
				end
			end
			S_W_STEP: begin
				fin_we = !has_edge && !pass_q;
			end
			S_W_NB: begin
				vis_ra = nb_u;
			end
			S_W_VIS: begin
				if (!vis_rd_q) begin
					vis_we = 1'b1; vis_wd = 1'b1;
					comp_we = pass_q;
					stk_we = 1'b1;
				end
			end
			S_CLR2: begin
				vis_we = 1'b1; vis_wa = idx_q[VW-1:0];
				comp_we = idx_q >= n; comp_wa = idx_q[VW-1:0]; comp_wd = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (oo_we) out_off[oo_wa] <= oo_wd;
		if (io_we) in_off[io_wa]  <= io_wd;
		oo_a_q <= out_off[oo_ra];
		oo_b_q <= out_off[oo_rb];
		io_a_q <= in_off[io_ra];
		io_b_q <= in_off[io_rb];
		if (onb_we) out_nb[onb_wa] <= onb_wd;
		if (inb_we) in_nb[inb_wa]  <= inb_wd;
		onb_q <= out_nb[cur_pos_q[EAW-1:0]];
		inb_q <= in_nb[cur_pos_q[EAW-1:0]];
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd_q <= vis_mem[vis_ra];
		if (fin_we) fin_mem[done_q[VW-1:0]] <= cur_v_q;
		fin_rd_q <= fin_mem[bi_m1[VW-1:0]];
		if (stk_we) stk_mem[depth_m1[VW-1:0]] <= '{v: cur_v_q, pos: cur_pos_q, lim: cur_end_q};
		stk_rd_q <= stk_mem[depth_m2[VW-1:0]];
		if (comp_we) comp_mem[comp_wa] <= comp_wd;
		q_data <= comp_mem[q_addr];
	end

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (go) state_d = S_CLR;
			S_CLR:      if (idx_q == LastV) state_d = S_CNT_RD;
			S_CNT_RD:   state_d = (ei_q == edge_total) ? S_PFX_RD : S_CNT_OFF;
			S_CNT_OFF:  state_d = e_keep ? S_CNT_WR : S_CNT_RD;
			S_CNT_WR:   state_d = S_CNT_RD;
			S_PFX_RD:   state_d = (idx_q == n) ? S_FIL_RD : S_PFX_WR;
			S_PFX_WR:   state_d = S_PFX_RD;
			S_FIL_RD:   state_d = (ei_q == edge_total) ? S_OUT_RD : S_FIL_OFF;
			S_FIL_OFF:  state_d = e_keep ? S_FIL_WR : S_FIL_RD;
			S_FIL_WR:   state_d = S_FIL_RD;
			S_OUT_RD:   state_d = (idx_q == n) ? S_CLR2 : S_OUT_CHK;
			S_BOUT_RD:  state_d = (bi_q == '0) ? S_FIN : S_BOUT_FIN;
			S_BOUT_FIN: state_d = S_OUT_CHK;
			S_OUT_CHK: begin
				if (!vis_rd_q) state_d = S_LOAD;
				else state_d = pass_q ? S_BOUT_RD : S_OUT_RD;
			end
			S_LOAD:     state_d = S_W_STEP;
			S_W_STEP: begin
				if (has_edge) state_d = S_W_NB;
				else if (depth_q > CW'(1)) state_d = S_W_POP;
				else state_d = pass_q ? S_BOUT_RD : S_OUT_RD;
			end
			S_W_NB:     state_d = S_W_VIS;
			S_W_VIS:    state_d = vis_rd_q ? S_W_STEP : S_LOAD;
			S_W_POP:    state_d = S_W_STEP;
			S_CLR2:     if (idx_q == LastV) state_d = S_BOUT_RD;
			S_FIN:      state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			comp_total_q   <= '0;
			labels_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN) begin
				comp_total_q   <= label_q;
				labels_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				idx_q <= '0;
				ei_q  <= '0;
			end
			S_CLR: idx_q <= idx_q + CW'(1);
			S_CNT_RD: begin
				idx_q  <= '0;
				osum_q <= '0;
				isum_q <= '0;
			end
			S_CNT_OFF, S_FIL_OFF: begin
				e_src_q <= edge_rd.src;
				e_dst_q <= edge_rd.dst;
				if (!e_keep) ei_q <= ei_q + EW'(1);
			end
			S_CNT_WR, S_FIL_WR: ei_q <= ei_q + EW'(1);
			S_PFX_RD: ei_q <= '0;
			S_PFX_WR: begin
				osum_q <= osum_q + oo_a_q;
				isum_q <= isum_q + io_a_q;
				idx_q  <= idx_q + CW'(1);
			end
			S_FIL_RD: begin
				idx_q  <= '0;
				pass_q <= 1'b0;
				done_q <= '0;
			end
			S_OUT_RD: begin
				tgt_q <= idx_q[VW-1:0];
				if (idx_q == n) idx_q <= '0;
			end
			S_BOUT_FIN: tgt_q <= fin_rd_q;
			S_OUT_CHK: begin
				if (!vis_rd_q) depth_q <= CW'(1);
				else if (pass_q) bi_q <= bi_m1;
				else idx_q <= idx_q + CW'(1);
			end
			S_LOAD: begin
				cur_v_q   <= tgt_q;
				cur_pos_q <= (tgt_q == '0) ? '0 : (pass_q ? io_a_q : oo_a_q);
				cur_end_q <= pass_q ? io_b_q : oo_b_q;
			end
			S_W_STEP: begin
				if (has_edge) begin
					cur_pos_q <= cur_pos_q + EW'(1);
				end else begin
					depth_q <= depth_m1;
					if (!pass_q) done_q <= done_q + CW'(1);
					if (depth_q == CW'(1)) begin
						if (pass_q) begin
							label_q <= label_q + CW'(1);
							bi_q    <= bi_m1;
						end else begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
			end
			S_W_NB: tgt_q <= nb_u;
			S_W_VIS: if (!vis_rd_q) depth_q <= depth_q + CW'(1);
			S_W_POP: begin
				cur_v_q   <= stk_rd_q.v;
				cur_pos_q <= stk_rd_q.pos;
				cur_end_q <= stk_rd_q.lim;
			end
			S_CLR2: begin
				idx_q   <= idx_q + CW'(1);
				bi_q    <= done_q;
				pass_q  <= 1'b1;
				label_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign stat = '{busy: state_q != S_IDLE, done: state_q == S_FIN,
		labels_valid: labels_valid_q, count: comp_total_q};

	`SCC_ASSERT(a_pos_within_list, clk, arst_n, (state_q == S_W_STEP) |-> (cur_pos_q <= cur_end_q), "adjacency position ran past the end of its list")
	`SCC_ASSERT(a_depth_in_range, clk, arst_n, (state_q == S_W_STEP) |-> (depth_q != '0 && depth_q <= CW'(MaxVertices)), "walk stack depth out of range")
	`SCC_ASSERT_NEXT(a_done_to_idle, clk, arst_n, stat.done, !stat.busy, "engine did not return to idle after finishing")

endmodule

/* rtl/strongly_connected_components_top.sv */
// Top level of the strongly connected components engine: command port,
// configuration register, edge store and result register. Depends on scc_pkg,
// scc_edge_store, scc_engine and the assertion macros.
//
//   Channel   Ports                      Transfer
//   request   start, busy, request       start high and busy low at a rising edge
//   config    cfg_wr_en, cfg_wr_data     cfg_wr_en high at a rising edge
//   result    result_valid, result       one cycle, cannot be held off
//
// Add, query and clear commands are taken one per cycle while busy is low; each
// result appears in the cycle after its transfer. A decompose command raises busy
// and holds it for the whole decomposition, which the engine runs as a sweep
// that clears the offset and visited memories, an edge count, a prefix sum over
// the vertices, an edge fill, the forward pass, a sweep that clears the visited
// memory and the labels above the vertex count, and the reverse pass. Its result
// is on the ports in the first cycle in which busy is low again. Reset clears the
// edge count and the component count and sets the vertex count to its maximum;
// labels read as zero until the first decompose writes them all, so no clearing
// pass runs after reset. The receiver never stalls the block.
`include "strongly_connected_components_top_macros.svh"
module strongly_connected_components_top import scc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  req_t          request,
	input  logic          cfg_wr_en,
	input  logic [CW-1:0] cfg_wr_data,
	output logic          result_valid,
	output res_t          result
);

	logic [CW-1:0]  vertex_count_q;
	logic [EW-1:0]  edge_total_q;
	logic [CW-1:0]  n;
	logic           accept, range_bad, store_full;
	logic [1:0]     status_d;
	logic           valid_s1, qhit_s1;
	logic [1:0]     status_s1;
	edge_wr_t       edge_wr;
	edge_pair_t     edge_rd;
	logic [EAW-1:0] edge_rd_addr;
	logic [VW-1:0]  q_data;
	eng_stat_t      stat;

	// The register may hold more than the vertex memories cover; saturate it.
	assign n = (vertex_count_q > CW'(MaxVertices)) ? CW'(MaxVertices) : vertex_count_q;

	assign accept     = start && !busy;
	assign range_bad  = ({1'b0, request.vertex} >= n) || ({1'b0, request.edge_target} >= n);
	assign store_full = edge_total_q == EW'(MaxEdges);
	assign busy       = stat.busy;

	always_comb begin
		unique case (request.req_type)
			REQ_ADD:   status_d = range_bad ? ST_RANGE : (store_full ? ST_FULL : ST_OK);
			REQ_QUERY: status_d = ({1'b0, request.vertex} >= n) ? ST_RANGE : ST_OK;
			default:   status_d = ST_OK;
		endcase
	end

	// An edge is stored only if both ends are in range and there is room.
	assign edge_wr = '{en: accept && request.req_type == REQ_ADD && !range_bad && !store_full,
		addr: edge_total_q[EAW-1:0],
		data: '{src: request.vertex, dst: request.edge_target}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= CW'(MaxVertices);
			edge_total_q   <= '0;
			valid_s1       <= 1'b0;
		end else begin
			if (cfg_wr_en) vertex_count_q <= cfg_wr_data;
			if (edge_wr.en) edge_total_q <= edge_total_q + EW'(1);
			else if (accept && request.req_type == REQ_CLEAR) edge_total_q <= '0;
			valid_s1 <= (accept && request.req_type != REQ_DECOMP) || stat.done;
		end
	end

	// Result payload; the label itself comes straight from the label memory's
	// registered read, which was addressed by the query in its transfer cycle.
	always_ff @(posedge clk) begin
		if (stat.done) begin
			status_s1 <= ST_OK;
			qhit_s1   <= 1'b0;
		end else begin
			status_s1 <= status_d;
			qhit_s1   <= request.req_type == REQ_QUERY && {1'b0, request.vertex} < n;
		end
	end

	assign result_valid = valid_s1;
	assign result = '{status: status_s1,
		component: (qhit_s1 && stat.labels_valid) ? q_data : '0,
		component_count: stat.count};

	scc_edge_store u_edges (
		.clk     (clk),
		.wr      (edge_wr),
		.rd_addr (edge_rd_addr),
		.rd_data (edge_rd)
	);

	scc_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.go           (accept && request.req_type == REQ_DECOMP),
		.n            (n),
		.edge_total   (edge_total_q),
		.edge_rd_addr (edge_rd_addr),
		.edge_rd      (edge_rd),
		.q_addr       (request.vertex),
		.q_data       (q_data),
		.stat         (stat)
	);

	`SCC_ASSERT_NEXT(a_cmd_result, clk, arst_n, accept && request.req_type != REQ_DECOMP, result_valid, "command transfer gave no result in the next cycle")
	`SCC_ASSERT_NEXT(a_decomp_busy, clk, arst_n, accept && request.req_type == REQ_DECOMP, busy && !result_valid, "decompose did not raise busy")
	`SCC_ASSERT(a_total_bound, clk, arst_n, edge_total_q <= EW'(MaxEdges), "edge count beyond the store size")

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for strongly_connected_components_top.
// It predicts every result with its own Kosaraju decomposition in scc_pkg types.
// Depends on scc_pkg and the top level.
module tb;
	import scc_pkg::*;

	// The longest decompose (MaxVertices vertices, MaxEdges edges) runs with no transfer at all,
	// so the watchdog limit is set well above its length.
	localparam int StallLimit = 300000;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	logic          busy;
	req_t          request = '0;
	logic          cfg_wr_en = 1'b0;
	logic [CW-1:0] cfg_wr_data = '0;
	logic          result_valid;
	res_t          result;

	strongly_connected_components_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.result_valid(result_valid),
		.result(result)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow state of the engine. Adjacency lists use offset arrays, like the
	// block, so edge order inside each list matches the block's walks.
	logic [VW-1:0] edge_src [MaxEdges];
	logic [VW-1:0] edge_dst [MaxEdges];
	int            edge_cnt;
	int            fwd_off [MaxVertices+1];
	int            rev_off [MaxVertices+1];
	logic [VW-1:0] fwd_nb [MaxEdges];
	logic [VW-1:0] rev_nb [MaxEdges];
	bit            seen [MaxVertices];
	logic [VW-1:0] finish_seq [MaxVertices];
	int            finish_cnt;
	logic [VW-1:0] walk_v [MaxVertices];
	int            walk_p [MaxVertices];
	logic [VW-1:0] label_of [MaxVertices];
	logic [CW-1:0] label_total;
	logic [CW-1:0] vcount;

	res_t result_fifo [$];
	int   mismatches = 0;
	int   sent_items = 0;
	int   decomps = 0;
	int   burst_left = 0;

	function automatic int active_vertices();
		return (vcount > MaxVertices) ? MaxVertices : int'(vcount);
	endfunction

	// Builds the forward list (rev = 0) or the reverse list (rev = 1); edges
	// with an endpoint outside the active range are left out.
	function automatic void build_adjacency(bit rev, int n);
		int cnt [MaxVertices+1];
		int k, d;
		for (int i = 0; i <= MaxVertices; i++) cnt[i] = 0;
		for (int i = 0; i < edge_cnt; i++) begin
			k = rev ? edge_dst[i] : edge_src[i];
			d = rev ? edge_src[i] : edge_dst[i];
			if (k < n && d < n) cnt[k+1]++;
		end
		for (int i = 0; i < n; i++) cnt[i+1] += cnt[i];
		for (int i = 0; i < edge_cnt; i++) begin
			k = rev ? edge_dst[i] : edge_src[i];
			d = rev ? edge_src[i] : edge_dst[i];
			if (k < n && d < n) begin
				if (rev) rev_nb[cnt[k]] = d[VW-1:0];
				else fwd_nb[cnt[k]] = d[VW-1:0];
				cnt[k]++;
			end
		end
		for (int i = n; i > 0; i--) cnt[i] = cnt[i-1];
		cnt[0] = 0;
		for (int i = 0; i <= MaxVertices; i++) begin
			if (rev) rev_off[i] = cnt[i];
			else fwd_off[i] = cnt[i];
		end
	endfunction

	// Iterative depth-first walk. On the forward graph it appends to the finish
	// sequence; on the reverse graph it labels every vertex it reaches.
	function automatic void dfs(int root, bit rev, logic [VW-1:0] lbl);
		int top, v, u;
		seen[root] = 1'b1;
		if (rev) label_of[root] = lbl;
		walk_v[0] = root[VW-1:0];
		walk_p[0] = rev ? rev_off[root] : fwd_off[root];
		top = 1;
		while (top > 0) begin
			v = walk_v[top-1];
			if (walk_p[top-1] < (rev ? rev_off[v+1] : fwd_off[v+1])) begin
				u = rev ? rev_nb[walk_p[top-1]] : fwd_nb[walk_p[top-1]];
				walk_p[top-1]++;
				if (!seen[u] && top < MaxVertices) begin
					seen[u] = 1'b1;
					if (rev) label_of[u] = lbl;
					walk_v[top] = u[VW-1:0];
					walk_p[top] = rev ? rev_off[u] : fwd_off[u];
					top++;
				end
			end else begin
				top--;
				if (!rev && finish_cnt < MaxVertices) begin
					finish_seq[finish_cnt] = v[VW-1:0];
					finish_cnt++;
				end
			end
		end
	endfunction

	function automatic void decompose_graph();
		int n, comps, v;
		n = active_vertices();
		build_adjacency(1'b0, n);
		build_adjacency(1'b1, n);
		for (int i = 0; i < MaxVertices; i++) seen[i] = 1'b0;
		finish_cnt = 0;
		for (int i = 0; i < n; i++)
			if (!seen[i]) dfs(i, 1'b0, '0);
		for (int i = 0; i < MaxVertices; i++) seen[i] = 1'b0;
		comps = 0;
		for (int i = finish_cnt; i > 0; i--) begin
			v = finish_seq[i-1];
			if (!seen[v]) begin
				dfs(v, 1'b1, comps[VW-1:0]);
				comps++;
			end
		end
		for (int i = n; i < MaxVertices; i++) label_of[i] = '0;
		label_total = comps[CW-1:0];
	endfunction

	// Applies one accepted command to the shadow state and returns its result.
	function automatic res_t predict_result(req_t r);
		res_t e;
		int n;
		n = active_vertices();
		e = '0;
		e.status = ST_OK;
		case (r.req_type)
			REQ_ADD: begin
				if (r.vertex >= n || r.edge_target >= n) e.status = ST_RANGE;
				else if (edge_cnt >= MaxEdges) e.status = ST_FULL;
				else begin
					edge_src[edge_cnt] = r.vertex;
					edge_dst[edge_cnt] = r.edge_target;
					edge_cnt++;
				end
			end
			REQ_DECOMP: decompose_graph();
			REQ_QUERY: begin
				if (r.vertex >= n) e.status = ST_RANGE;
				else e.component = label_of[r.vertex];
			end
			default: edge_cnt = 0;
		endcase
		e.component_count = label_total;
		return e;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		mismatches++;
		$display("MISMATCH at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
	endtask

	// Results cannot be held off, so every strobe is checked at the edge that
	// ends its cycle against the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && result_valid) begin
			if (result_fifo.size() == 0) begin
				report_mismatch("unexpected result, status", result.status, -1);
			end else begin
				want = result_fifo.pop_front();
				if (result.status !== want.status)
					report_mismatch("status", result.status, want.status);
				if (result.component !== want.component)
					report_mismatch("component", result.component, want.component);
				if (result.component_count !== want.component_count)
					report_mismatch("component_count", result.component_count,
						want.component_count);
			end
		end
	end

	// Watchdog: any request transfer or result clears the count of dead cycles.
	int dead_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) dead_cycles <= 0;
		else dead_cycles <= dead_cycles + 1;
		if (dead_cycles >= StallLimit) begin
			$display("watchdog: no transfer for %0d cycles", StallLimit);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Sends one command. Start is left high on return, so the caller either
	// sends the next command in the same step or lowers start in that step.
	task automatic send_cmd(logic [1:0] kind, int v, int t);
		req_t r;
		r.req_type = kind;
		r.vertex = v[VW-1:0];
		r.edge_target = t[VW-1:0];
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		result_fifo.insert(result_fifo.size(), predict_result(r));
		sent_items++;
		if (kind == REQ_DECOMP) decomps++;
	endtask

	// Sender pacing: bursts of random length separated by random gaps.
	// A zero gap keeps start high so it is never lowered and raised in one step.
	task automatic paced_cmd(logic [1:0] kind, int v, int t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		send_cmd(kind, v, t);
	endtask

	// Lowers start and waits until every predicted result has come back, then
	// waits out a margin for the result register.
	task automatic drain();
		start <= 1'b0;
		while (result_fifo.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_vertex_count(int value);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value[CW-1:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		vcount = value[CW-1:0];
		@(posedge clk);
	endtask

	// Extremes of the fields, every command, range errors, saturation of the
	// vertex count, zero vertices and the label reset after a shrink.
	task automatic test_directed();
		send_cmd(REQ_QUERY, 0, 0);
		send_cmd(REQ_QUERY, 1023, 1023);
		send_cmd(REQ_ADD, 1023, 0);
		send_cmd(REQ_ADD, 0, 1023);
		send_cmd(REQ_ADD, 5, 5);
		send_cmd(REQ_DECOMP, 0, 0);
		send_cmd(REQ_QUERY, 1023, 0);
		send_cmd(REQ_QUERY, 5, 0);
		set_vertex_count(0);
		send_cmd(REQ_ADD, 0, 0);
		send_cmd(REQ_QUERY, 0, 0);
		send_cmd(REQ_DECOMP, 0, 0);
		send_cmd(REQ_QUERY, 1023, 0);
		set_vertex_count(2047);
		send_cmd(REQ_QUERY, 1023, 0);
		send_cmd(REQ_ADD, 682, 341);
		send_cmd(REQ_CLEAR, 1023, 1023);
		set_vertex_count(1);
		send_cmd(REQ_ADD, 0, 0);
		send_cmd(REQ_ADD, 0, 1);
		send_cmd(REQ_ADD, 1, 0);
		send_cmd(REQ_DECOMP, 0, 0);
		send_cmd(REQ_QUERY, 0, 0);
		send_cmd(REQ_QUERY, 1, 0);
		send_cmd(REQ_CLEAR, 0, 0);
		drain();
	endtask

	// Loads edges on six vertices, then shrinks to three so that most stored
	// edges are stale when the decompose runs.
	task automatic test_stale_edges();
		set_vertex_count(6);
		for (int i = 0; i < 24; i++)
			send_cmd(REQ_ADD, $urandom_range(0, 5), $urandom_range(0, 5));
		send_cmd(REQ_ADD, 6, 0);
		set_vertex_count(3);
		send_cmd(REQ_DECOMP, 0, 0);
		for (int v = 0; v < 7; v++) send_cmd(REQ_QUERY, v, 0);
		send_cmd(REQ_CLEAR, 0, 0);
		drain();
	endtask

	// Random graphs: each phase sets a vertex count, loads edges (some of them
	// rings so that real cycles form), decomposes, queries up to 40 vertices.
	task automatic test_random_graphs();
		int n, edges, a, b, ring, pick;
		while (sent_items < 1400) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) n = $urandom_range(1, 12);
			else if (pick < 9) n = $urandom_range(13, 64);
			else n = $urandom_range(65, 200);
			set_vertex_count(n);
			paced_cmd(REQ_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
			edges = $urandom_range(0, 2 * n + 2);
			for (int i = 0; i < edges; i++) begin
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					a = $urandom_range(0, 1023);
					b = $urandom_range(0, 1023);
					paced_cmd(REQ_ADD, a, b);
				end else if (pick == 1) begin
					// Ring through a few vertices: one component for all of them.
					a = $urandom_range(0, n - 1);
					ring = $urandom_range(2, 5);
					b = a;
					for (int j = 0; j < ring - 1; j++) begin
						pick = $urandom_range(0, n - 1);
						paced_cmd(REQ_ADD, b, pick);
						b = pick;
					end
					paced_cmd(REQ_ADD, b, a);
				end else begin
					paced_cmd(REQ_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
				end
			end
			if ($urandom_range(0, 4) == 0) paced_cmd(2'($urandom_range(0, 3)),
				$urandom_range(0, 1023), $urandom_range(0, 1023));
			if ($urandom_range(0, 5) == 0 && n > 1) begin
				// Shrink before decomposing so some stored edges go stale.
				set_vertex_count($urandom_range(1, n - 1));
				n = active_vertices();
			end
			paced_cmd(REQ_DECOMP, $urandom_range(0, 1023), $urandom_range(0, 1023));
			for (int v = 0; v < n + 2 && v < 40; v++) paced_cmd(REQ_QUERY, v, 0);
			paced_cmd(REQ_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023));
			drain();
		end
	endtask

	initial begin
		edge_cnt = 0;
		label_total = '0;
		vcount = CW'(MaxVertices);
		for (int i = 0; i < MaxVertices; i++) label_of[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_stale_edges();
		test_random_graphs();
		drain();
		repeat (20) @(posedge clk);
		$display("covered %0d commands, %0d decompositions, range errors, stale edges",
			sent_items, decomps);
		$display("and vertex counts from zero to saturation with random sender gaps");
		if (mismatches == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl
rtl/scc_pkg.sv
rtl/scc_edge_store.sv
rtl/scc_engine.sv
rtl/strongly_connected_components_top.sv
verif/tb.sv
